### hw/rtl/eip_pkg.sv
// Shared codes for the eased interpolator: curve selectors and easing modes.
package eip_pkg;

    localparam int REQ_W = 3;
    localparam logic [REQ_W-1:0] REQ_IN_QUAD    = 3'd1;
    localparam logic [REQ_W-1:0] REQ_OUT_QUAD   = 3'd2;
    localparam logic [REQ_W-1:0] REQ_INOUT_QUAD = 3'd3;
    localparam logic [REQ_W-1:0] REQ_OUT_BOUNCE = 3'd4;

    localparam int MODE_W = 3;
    typedef logic [MODE_W-1:0] mode_t;
    localparam mode_t MODE_LIN       = 3'd0;
    localparam mode_t MODE_SQ        = 3'd1;
    localparam mode_t MODE_ONE_SQ    = 3'd2;
    localparam mode_t MODE_TWO_SQ    = 3'd3;
    localparam mode_t MODE_ONE_TWOSQ = 3'd4;
    localparam mode_t MODE_BOUNCE    = 3'd5;

endpackage

### hw/rtl/eip_fifo.sv
// Small register queue with level output.
module eip_fifo
    import eip_pkg::*;
#(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    input  logic [WIDTH-1:0]             wdata,
    output logic                         full,
    input  logic                         pop,
    output logic [WIDTH-1:0]             rdata,
    output logic                         empty,
    output logic [$clog2(DEPTH+1)-1:0]   level
);

    localparam int PW = $clog2(DEPTH);
    localparam int LW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [LW-1:0]    level_reg, level_next;
    logic             do_push, do_pop;

    assign full    = (level_reg == LW'(DEPTH));
    assign empty   = (level_reg == '0);
    assign level   = level_reg;
    assign rdata   = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        level_next  = level_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            level_next = level_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            level_next = level_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

### hw/rtl/eip_front.sv
// Front end: phase clamp, curve classification, operand and offset selection.
module eip_front
    import eip_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic signed [31:0]        start_value,
    input  logic signed [31:0]        end_value,
    input  logic signed [31:0]        phase,
    input  logic [REQ_W-1:0]          req_type,
    output logic signed [31:0]        diff,
    output mode_t                     mode,
    output logic [FRAC_BITS:0]        op,
    output logic [FRAC_BITS:0]        offset
);

    localparam int TW   = FRAC_BITS + 1;
    localparam int OneI = 1 << FRAC_BITS;
    localparam logic [TW-1:0] ONE  = TW'(OneI);
    localparam logic [TW-1:0] HALF = TW'(OneI / 2);
    localparam logic [TW-1:0] BP1  = TW'((4 * OneI) / 11);
    localparam logic [TW-1:0] BP2  = TW'((8 * OneI) / 11);
    localparam logic [TW-1:0] BP3  = TW'((10 * OneI) / 11);
    localparam logic [TW-1:0] CT1  = TW'((6 * OneI) / 11);
    localparam logic [TW-1:0] CT2  = TW'((9 * OneI) / 11);
    localparam logic [TW-1:0] CT3  = TW'(((21 * OneI) / 2) / 11);
    localparam logic [TW-1:0] OFF1 = TW'((3 * OneI) / 4);
    localparam logic [TW-1:0] OFF2 = TW'((15 * OneI) / 16);
    localparam logic [TW-1:0] OFF3 = TW'((63 * OneI) / 64);

    logic [TW-1:0] t;
    logic [TW-1:0] center;
    logic [TW-1:0] b_off;
    logic [TW-1:0] b_op;

    assign diff = end_value - start_value;

    always_comb
    begin
        if (phase[31])
        begin
            t = '0;
        end
        else if (phase > $signed(32'(OneI)))
        begin
            t = ONE;
        end
        else
        begin
            t = phase[TW-1:0];
        end
    end

    always_comb
    begin
        center = '0;
        b_off  = '0;
        if (t < BP1)
        begin
            center = '0;
            b_off  = '0;
        end
        else if (t < BP2)
        begin
            center = CT1;
            b_off  = OFF1;
        end
        else if (t < BP3)
        begin
            center = CT2;
            b_off  = OFF2;
        end
        else
        begin
            center = CT3;
            b_off  = OFF3;
        end
        b_op = (t >= center) ? (t - center) : (center - t);
    end

    always_comb
    begin
        offset = '0;
        case (req_type)
            REQ_IN_QUAD:
            begin
                mode = MODE_SQ;
                op   = t;
            end
            REQ_OUT_QUAD:
            begin
                mode = MODE_ONE_SQ;
                op   = ONE - t;
            end
            REQ_INOUT_QUAD:
            begin
                if (t < HALF)
                begin
                    mode = MODE_TWO_SQ;
                    op   = t;
                end
                else
                begin
                    mode = MODE_ONE_TWOSQ;
                    op   = ONE - t;
                end
            end
            REQ_OUT_BOUNCE:
            begin
                mode   = MODE_BOUNCE;
                op     = b_op;
                offset = b_off;
            end
            default:
            begin
                mode = MODE_LIN;
                op   = t;
            end
        endcase
    end

endmodule

### hw/rtl/eip_back.sv
// Back end: square, easing weight, scaled difference and final sum pipeline.
module eip_back
    import eip_pkg::*;
#(
    parameter int FRAC_BITS = 16,
    parameter int OUT_DEPTH = 8
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_take,
    input  logic signed [31:0]                 in_start,
    input  logic signed [31:0]                 in_diff,
    input  mode_t                              in_mode,
    input  logic [FRAC_BITS:0]                 in_op,
    input  logic [FRAC_BITS:0]                 in_offset,
    input  logic [$clog2(OUT_DEPTH+1)-1:0]     out_level,
    output logic                               out_valid,
    output logic signed [31:0]                 out_value
);

    localparam int TW = FRAC_BITS + 1;
    localparam int EW = FRAC_BITS + 2;
    localparam int PW = 33 + EW;
    localparam int LW = $clog2(OUT_DEPTH + 1);
    localparam int CW = LW + 1;
    localparam logic [EW-1:0] ONE = EW'(1 << FRAC_BITS);

    logic                 v1_reg, v2_reg, v3_reg, v4_reg;
    logic [2*TW-1:0]      sq1_reg, sq1_next;
    mode_t                mode1_reg;
    logic [TW-1:0]        op1_reg, off1_reg;
    logic signed [31:0]   diff1_reg, diff2_reg;
    logic signed [31:0]   start1_reg, start2_reg, start3_reg;
    logic [EW-1:0]        e2_reg, e2_next;
    logic signed [PW-1:0] prod3_reg, prod3_next;
    logic signed [31:0]   value4_reg, value4_next;

    logic [TW-1:0]        s;
    logic [TW+6:0]        s121;
    logic [CW-1:0]        total;

    assign total = CW'(v1_reg) + CW'(v2_reg) + CW'(v3_reg) + CW'(v4_reg) + CW'(out_level);
    assign in_take = in_valid && (total < CW'(OUT_DEPTH));

    assign sq1_next = (2*TW)'(in_op) * (2*TW)'(in_op);

    assign s    = sq1_reg[FRAC_BITS +: TW];
    assign s121 = (TW+7)'(s) * (TW+7)'(121);

    always_comb
    begin
        case (mode1_reg)
            MODE_LIN:       e2_next = EW'(op1_reg);
            MODE_SQ:        e2_next = EW'(s);
            MODE_ONE_SQ:    e2_next = ONE - EW'(s);
            MODE_TWO_SQ:    e2_next = EW'(s) << 1;
            MODE_ONE_TWOSQ: e2_next = ONE - (EW'(s) << 1);
            MODE_BOUNCE:    e2_next = EW'(s121 >> 4) + EW'(off1_reg);
            default:        e2_next = EW'(op1_reg);
        endcase
    end

    assign prod3_next  = PW'(diff2_reg) * $signed({1'b0, e2_reg});
    assign value4_next = start3_reg + prod3_reg[FRAC_BITS +: 32];

    assign out_valid = v4_reg;
    assign out_value = value4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_take;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        sq1_reg    <= sq1_next;
        mode1_reg  <= in_mode;
        op1_reg    <= in_op;
        off1_reg   <= in_offset;
        diff1_reg  <= in_diff;
        start1_reg <= in_start;
        e2_reg     <= e2_next;
        diff2_reg  <= diff1_reg;
        start2_reg <= start1_reg;
        prod3_reg  <= prod3_next;
        start3_reg <= start2_reg;
        value4_reg <= value4_next;
    end

endmodule

### hw/rtl/eased_interpolator_fixed_point.sv
// Eased interpolator top level: input queue, front end, back pipeline, result queue.
//
// Use: a request carries start_value, end_value, phase (signed fixed point with
// FRAC_BITS fraction bits) and req_type (1 in-quad, 2 out-quad, 3 in-out quad,
// 4 bounce out, others linear). Each request gives one result on value.
// Input side is a queue write port: a request is taken when push is high and
// full is low. Output side is a queue read port: value holds the oldest result
// while empty is low; pop with empty low takes it.
// Path: a taken request passes the request queue, then the square, easing
// weight, scaling multiply and final add registers, then the result queue.
// Throughput: one request per cycle while the result queue has room, set by the fully pipelined multipliers.
// Stalls: the back end only issues while the result queue has a free slot for
// every request in flight, so a stalled reader fills the result queue, then
// the request queue, and full rises; nothing is dropped.
// Reset: rst_n clears both queues and the pipeline valid bits; no other state.
module eased_interpolator_fixed_point
    import eip_pkg::*;
#(
    parameter int FRAC_BITS = 16,
    parameter int MID_DEPTH = 4,
    parameter int OUT_DEPTH = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic signed [31:0]   start_value,
    input  logic signed [31:0]   end_value,
    input  logic signed [31:0]   phase,
    input  logic [REQ_W-1:0]     req_type,
    output logic                 empty,
    input  logic                 pop,
    output logic signed [31:0]   value
);

    localparam int TW  = FRAC_BITS + 1;
    localparam int MW  = 64 + MODE_W + 2 * TW;
    localparam int MLW = $clog2(MID_DEPTH + 1);
    localparam int OLW = $clog2(OUT_DEPTH + 1);

    logic signed [31:0] f_diff;
    mode_t              f_mode;
    logic [TW-1:0]      f_op, f_offset;

    logic [MW-1:0]      mid_wdata, mid_rdata;
    logic               mid_empty;
    logic [MLW-1:0]     mid_level;

    logic               b_take;
    logic               b_valid;
    logic signed [31:0] b_value;
    logic               out_full;
    logic [OLW-1:0]     out_level;

    eip_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .start_value (start_value),
        .end_value   (end_value),
        .phase       (phase),
        .req_type    (req_type),
        .diff        (f_diff),
        .mode        (f_mode),
        .op          (f_op),
        .offset      (f_offset)
    );

    assign mid_wdata = {start_value, f_diff, f_mode, f_op, f_offset};

    eip_fifo #(
        .WIDTH (MW),
        .DEPTH (MID_DEPTH)
    ) u_mid_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (mid_wdata),
        .full  (full),
        .pop   (b_take),
        .rdata (mid_rdata),
        .empty (mid_empty),
        .level (mid_level)
    );

    eip_back #(
        .FRAC_BITS (FRAC_BITS),
        .OUT_DEPTH (OUT_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (!mid_empty && (mid_level != '0)),
        .in_take   (b_take),
        .in_start  (mid_rdata[MW-1 -: 32]),
        .in_diff   (mid_rdata[MW-33 -: 32]),
        .in_mode   (mid_rdata[2*TW +: MODE_W]),
        .in_op     (mid_rdata[TW +: TW]),
        .in_offset (mid_rdata[0 +: TW]),
        .out_level (out_level),
        .out_valid (b_valid),
        .out_value (b_value)
    );

    eip_fifo #(
        .WIDTH (32),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (b_valid && !out_full),
        .wdata (b_value),
        .full  (out_full),
        .pop   (pop),
        .rdata (value),
        .empty (empty),
        .level (out_level)
    );

endmodule
